>>> rtl/lps_pkg.sv
// ============================================================================
// lps_pkg
// Shared constants and controller-to-datapath types for the Legendre
// polynomial sequence generator.
// ============================================================================
package lps_pkg;

    localparam int unsigned XW         = 32;             // Q2.30 word width
    localparam int unsigned DW         = 5;              // degree width
    localparam int unsigned MAX_DEGREE = 31;             // highest degree served
    localparam int unsigned QFRAC      = 30;             // fraction bits
    localparam int unsigned NUMW       = 68;             // signed numerator width
    localparam int unsigned DIVW       = NUMW - QFRAC;   // dividend / quotient bits
    localparam int unsigned REMW       = DW + 1;         // partial remainder bits
    localparam int unsigned CNTW       = 6;              // division step counter
    localparam int unsigned DIV_STEPS  = DIVW;           // one quotient bit a step

    localparam logic signed [XW-1:0] Q_ONE     = 32'sd1073741824;
    localparam logic signed [XW-1:0] Q_NEG_ONE = -32'sd1073741824;

    localparam logic [DW-1:0] MAX_DEGREE_RESET = 5'd8;

    // Commands from the controller to the datapath, at most one strobe high.
    typedef struct packed {
        logic          load;      // capture the clamped argument, P = 1
        logic          advance1;  // P_1 = x
        logic          mul;       // x * P_l
        logic          num;       // form the rounded numerator magnitude
        logic          div_step;  // one restoring division step
        logic          commit;    // sign, clamp and shift the term pair
        logic [DW-1:0] degree;    // degree of the term being computed
    } t_dp_cmd;

endpackage

>>> rtl/lps_datapath.sv
// ============================================================================
// lps_datapath
// Term registers, multiplier and bit-serial divider of the recurrence.
// ============================================================================
module lps_datapath (
    input  logic                           i_clk,
    input  lps_pkg::t_dp_cmd               i_cmd,
    input  logic signed [lps_pkg::XW-1:0]  i_x_value,
    output logic signed [lps_pkg::XW-1:0]  o_term
);
    import lps_pkg::*;

    logic signed [XW-1:0]     r_x, r_pp, r_pc;
    logic signed [2*XW-1:0]   r_prod;
    logic [DIVW-1:0]          r_dvd;
    logic [REMW-1:0]          r_rem;
    logic                     r_neg;

    logic signed [XW-1:0]     w_x_clamped;
    logic [DW:0]              w_c2;
    logic [DW-1:0]            w_l;
    logic signed [DIVW-1:0]   w_lpp;
    logic signed [NUMW-1:0]   w_num;
    logic [NUMW-1:0]          w_mag;
    logic [NUMW-1:0]          w_rounded;
    logic [REMW-1:0]          w_trial;
    logic                     w_qbit;
    logic [QFRAC:0]           w_qmag;
    logic signed [XW-1:0]     w_next;

    always_comb begin
        if (i_x_value > Q_ONE) begin
            w_x_clamped = Q_ONE;
        end else if (i_x_value < Q_NEG_ONE) begin
            w_x_clamped = Q_NEG_ONE;
        end else begin
            w_x_clamped = i_x_value;
        end
    end

    // For degree d: l = d - 1, 2l + 1 = 2d - 1, divisor d * 2^30.
    assign w_l   = i_cmd.degree - 5'd1;
    assign w_c2  = {i_cmd.degree, 1'b0} - 6'd1;
    assign w_lpp = $signed({1'b0, w_l}) * r_pp;
    assign w_num = $signed({1'b0, w_c2}) * NUMW'(r_prod) - (NUMW'(w_lpp) <<< QFRAC);
    assign w_mag = w_num[NUMW-1] ? NUMW'(-w_num) : NUMW'(w_num);
    // Adding half the divisor turns the floor into round-half-up on the magnitude.
    assign w_rounded = w_mag + (NUMW'(i_cmd.degree) << (QFRAC - 1));

    assign w_trial = {r_rem[REMW-2:0], r_dvd[DIVW-1]};
    assign w_qbit  = (w_trial >= REMW'(i_cmd.degree));

    // r_dvd holds the quotient once all steps are done.
    assign w_qmag = (r_dvd > DIVW'(Q_ONE)) ? (QFRAC+1)'(Q_ONE) : r_dvd[QFRAC:0];
    assign w_next = r_neg ? -$signed({1'b0, w_qmag}) : $signed({1'b0, w_qmag});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x  <= w_x_clamped;
            r_pp <= '0;
            r_pc <= Q_ONE;
        end
        if (i_cmd.advance1) begin
            r_pp <= r_pc;
            r_pc <= r_x;
        end
        if (i_cmd.mul) begin
            r_prod <= r_x * r_pc;
        end
        if (i_cmd.num) begin
            r_dvd <= w_rounded[NUMW-1:QFRAC];
            r_neg <= w_num[NUMW-1];
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_qbit ? w_trial - REMW'(i_cmd.degree) : w_trial;
            r_dvd <= {r_dvd[DIVW-2:0], w_qbit};
        end
        if (i_cmd.commit) begin
            r_pp <= r_pc;
            r_pc <= w_next;
        end
    end

    assign o_term = r_pc;

endmodule

>>> rtl/lps_controller.sv
// ============================================================================
// lps_controller
// Sequencer of the recurrence: degree count, division steps, result strobe.
// ============================================================================
module lps_controller (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_cfg_valid,
    input  logic [lps_pkg::DW-1:0]      i_cfg_data,
    output logic                        o_cfg_ready,
    output lps_pkg::t_dp_cmd            o_cmd,
    output logic                        o_valid,
    output logic [lps_pkg::DW-1:0]      o_degree,
    output logic                        o_last
);
    import lps_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EMIT   = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_NUM    = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_COMMIT = 3'd5;

    logic [2:0]      r_state, n_state;
    logic [DW-1:0]   r_deg, n_deg;
    logic [DW-1:0]   r_top, n_top;
    logic [DW-1:0]   r_max_degree;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            w_last;

    assign w_last      = (r_deg == r_top);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state = r_state;
        n_deg   = r_deg;
        n_top   = r_top;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.degree = r_deg;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_deg   = '0;
                    n_top   = (32'(r_max_degree) > MAX_DEGREE) ? DW'(MAX_DEGREE)
                                                               : r_max_degree;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_deg = r_deg + 5'd1;
                    if (r_deg == '0) begin
                        o_cmd.advance1 = 1'b1;
                    end else begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_NUM;
            end
            ST_NUM: begin
                o_cmd.num = 1'b1;
                n_cnt     = '0;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == CNTW'(DIV_STEPS - 1)) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_EMIT;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_deg        <= '0;
            r_top        <= '0;
            r_cnt        <= '0;
            r_max_degree <= MAX_DEGREE_RESET;
        end else begin
            r_state <= n_state;
            r_deg   <= n_deg;
            r_top   <= n_top;
            r_cnt   <= n_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_degree <= i_cfg_data;
            end
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = (r_state == ST_EMIT);
    assign o_degree = r_deg;
    assign o_last   = o_valid && w_last;

endmodule

>>> rtl/legendre_polynomial_sequence.sv
// ============================================================================
// legendre_polynomial_sequence
// Emits P_0(x) .. P_n(x) for each argument x, n set by the max_degree register.
// ============================================================================
// Usage. An argument transfer happens at a rising edge where start is high and
// busy is low; i_x_value is a signed Q2.30 number and is clamped to [-1, 1].
// The block then emits one result per degree 0 .. n, in rising order, each on
// o_degree / o_poly_value / o_last for exactly one cycle with o_valid high.
// o_last marks the result of degree n. The receiver cannot stall: every
// result transfer completes in the cycle that it is shown.
// Timing. Degree 0 appears the cycle after the start transfer and degree 1 in
// the cycle after that. Every further degree passes through one multiply of x
// by P_l, a step forming the rounded numerator, 38 steps of the bit-serial
// restoring divider (one quotient bit a cycle), a commit step and the cycle
// in which the result is shown. busy stays high from the start transfer until
// the result of degree n has been shown; a new start is taken once busy is
// low.
// Configuration. max_degree (5 bits, reset value 8) is written through the
// i_cfg_valid / i_cfg_data channel, which is always ready; write it only while
// busy is low. Reset is synchronous and active low; it returns the sequencer
// to idle and max_degree to 8.
// ============================================================================
module legendre_polynomial_sequence (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [lps_pkg::XW-1:0]  i_x_value,
    input  logic                           i_cfg_valid,
    input  logic [lps_pkg::DW-1:0]         i_cfg_data,
    output logic                           o_cfg_ready,
    output logic                           o_valid,
    output logic [lps_pkg::DW-1:0]         o_degree,
    output logic signed [lps_pkg::XW-1:0]  o_poly_value,
    output logic                           o_last
);
    import lps_pkg::*;

    // Command bundle from the sequencer; the datapath has no state machine.
    t_dp_cmd w_cmd;

    lps_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd),
        .o_valid     (o_valid),
        .o_degree    (o_degree),
        .o_last      (o_last)
    );

    // The current term register drives the result value directly; it is
    // stable for the whole emit cycle of each degree.
    lps_datapath u_dp (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_x_value (i_x_value),
        .o_term    (o_poly_value)
    );

endmodule
